// ===== hdl/euler_angle_vector_rotation_unit_macros.svh =====
// assertion macros for the euler angle vector rotation unit
// expects clk and rst_n in the scope of the including module
`ifndef EULER_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH
`define EULER_ANGLE_VECTOR_ROTATION_UNIT_MACROS_SVH

// condition that must hold at every edge out of reset
`define EAV_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("eav: invariant violated");

// condition in one cycle implies another in the next cycle
`define EAV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eav: sequence check failed");

`endif

// ===== hdl/eav_pkg.sv =====
// shared constants, codes and coefficient tables of the euler rotation unit
// no dependencies
package eav_pkg;

  localparam int TRIG_BITS_DEF = 16;
  localparam int ANGLE_W       = 16;
  localparam int VEC_IN_W      = 32;
  // vector width inside the rotation stages: four bits wider than the input vector
  localparam int VEC_W         = 36;
  localparam int SERIES_STEPS  = 5;
  localparam int TRIG_LAT      = 21;
  localparam int ROT_STAGES    = 3;
  localparam int PIPE_LEN      = TRIG_LAT + 2 * ROT_STAGES + 1;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;
  typedef enum logic [1:0] {AX_ROLL, AX_PITCH, AX_YAW} axis_t;

  // series denominators, sine uses the first four steps
  function automatic logic [6:0] den_sin(input int j);
    logic [6:0] d;
    case (j)
      0: d = 7'd72;
      1: d = 7'd42;
      2: d = 7'd20;
      default: d = 7'd6;
    endcase
    return d;
  endfunction

  function automatic logic [6:0] den_cos(input int j);
    logic [6:0] d;
    case (j)
      0: d = 7'd90;
      1: d = 7'd56;
      2: d = 7'd30;
      3: d = 7'd12;
      default: d = 7'd2;
    endcase
    return d;
  endfunction

  // floor(2^30 / d) for the matching denominators
  function automatic logic [29:0] rcp_sin(input int j);
    logic [29:0] r;
    case (j)
      0: r = 30'd14913080;
      1: r = 30'd25565281;
      2: r = 30'd53687091;
      default: r = 30'd178956970;
    endcase
    return r;
  endfunction

  function automatic logic [29:0] rcp_cos(input int j);
    logic [29:0] r;
    case (j)
      0: r = 30'd11930464;
      1: r = 30'd19173961;
      2: r = 30'd35791394;
      3: r = 30'd89478485;
      default: r = 30'd536870912;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/eav_sincos.sv =====
// pipelined sine and cosine of an angle in hundredths of a degree
// depends on eav_pkg; every stage advances only while en is high
module eav_sincos #(
  parameter int TRIG_BITS = eav_pkg::TRIG_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [eav_pkg::ANGLE_W-1:0] angle,
  output logic signed [TRIG_BITS+1:0]   sin_o,
  output logic signed [TRIG_BITS+1:0]   cos_o
);

  localparam int STEPS = eav_pkg::SERIES_STEPS;
  localparam int SH    = 30 - TRIG_BITS;
  localparam logic [30:0] HALF = 31'(1) << (SH - 1);

  // reduce to [0,36000), quadrant and folded angle in [0,4500]
  logic [15:0] red;
  logic [13:0] fq;
  logic [12:0] g;
  eav_pkg::quad_t quad;

  always_comb begin
    red = angle[15] ? 16'({angle[15], angle} + 17'sd36000) : 16'(angle);
    if (red >= 16'd27000) begin
      quad = eav_pkg::QUAD_3;
      fq   = 14'(red - 16'd27000);
    end else if (red >= 16'd18000) begin
      quad = eav_pkg::QUAD_2;
      fq   = 14'(red - 16'd18000);
    end else if (red >= 16'd9000) begin
      quad = eav_pkg::QUAD_1;
      fq   = 14'(red - 16'd9000);
    end else begin
      quad = eav_pkg::QUAD_0;
      fq   = red[13:0];
    end
    g = (fq > 14'd4500) ? 13'(14'd9000 - fq) : fq[12:0];
  end

  logic [12:0] g0_r;
  eav_pkg::quad_t q0_r, q1_r, q2_r, q3_r, q4_r;
  logic sw0_r, sw1_r, sw2_r, sw3_r, sw4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g0_r  <= g;
      q0_r  <= quad;
      sw0_r <= (fq > 14'd4500);
    end
  end

  // radians in q30: g*187403 + floor(g*5426/18000)
  logic [30:0] a1_full;
  logic [24:0] n1;
  logic [29:0] a1_r, a2_r;
  logic [24:0] n1_r;
  assign a1_full = 31'(g0_r) * 31'd187403;
  assign n1      = 25'(g0_r) * 25'd5426;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= a1_full[29:0];
      n1_r  <= n1;
      q1_r  <= q0_r;
      sw1_r <= sw0_r;
    end
  end

  // floor(n/18000) = floor((n>>4)/1125) by reciprocal and one correction
  logic [20:0] m2;
  logic [31:0] qm2;
  logic [20:0] m2_r;
  logic [31:0] qm2_r;
  assign m2  = n1_r[24:4];
  assign qm2 = 32'(m2) * 32'd1864;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r  <= m2;
      qm2_r <= qm2;
      a2_r  <= a1_r;
      q2_r  <= q1_r;
      sw2_r <= sw1_r;
    end
  end

  logic [10:0] dq3;
  logic [20:0] rr3;
  logic [29:0] x3, x3_r;
  assign dq3 = qm2_r[31:21];
  assign rr3 = m2_r - 21'(dq3) * 21'd1125;
  assign x3  = a2_r + 30'(dq3) + 30'(rr3 >= 21'd1125);

  always_ff @(posedge clk) begin
    if (en) begin
      x3_r  <= x3;
      q3_r  <= q2_r;
      sw3_r <= sw2_r;
    end
  end

  // squared angle in q30
  logic [59:0] xx4;
  logic [29:0] x4_r, x24_r;
  assign xx4 = 60'(x3_r) * 60'(x3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x4_r  <= x3_r;
      x24_r <= xx4[59:30];
      q4_r  <= q3_r;
      sw4_r <= sw3_r;
    end
  end

  // horner series chain, three stages per term
  logic [30:0] ts_c [STEPS+1];
  logic [30:0] tc_c [STEPS+1];
  logic [29:0] x_c  [STEPS+1];
  logic [29:0] x2_c [STEPS+1];
  eav_pkg::quad_t q_c [STEPS+1];
  logic sw_c [STEPS+1];

  assign ts_c[0] = eav_pkg::Q30_ONE;
  assign tc_c[0] = eav_pkg::Q30_ONE;
  assign x_c[0]  = x4_r;
  assign x2_c[0] = x24_r;
  assign q_c[0]  = q4_r;
  assign sw_c[0] = sw4_r;

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [6:0]  DS = eav_pkg::den_sin(j);
    localparam logic [6:0]  DC = eav_pkg::den_cos(j);
    localparam logic [29:0] RS = eav_pkg::rcp_sin(j);
    localparam logic [29:0] RC = eav_pkg::rcp_cos(j);

    logic [29:0] ms_op;
    logic [60:0] ms, mc;
    logic [29:0] psa_r, pca_r, psb_r, pcb_r;
    logic [59:0] qsb, qcb, qsb_r, qcb_r;
    logic [29:0] xa_r, x2a_r, xb_r, x2b_r, xc_r, x2c_r;
    eav_pkg::quad_t qa_r, qb_r, qc_r;
    logic swa_r, swb_r, swc_r;
    logic [30:0] tsc_r, tcc_r;
    logic [30:0] ts_nxt, tc_nxt;
    logic [29:0] dqs, dqc;
    logic [30:0] rrs, rrc;

    // last sine term multiplies by the angle itself
    assign ms_op = (j == STEPS - 1) ? x_c[j] : x2_c[j];
    assign ms    = 61'(ms_op) * 61'(ts_c[j]);
    assign mc    = 61'(x2_c[j]) * 61'(tc_c[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        psa_r <= ms[59:30];
        pca_r <= mc[59:30];
        xa_r  <= x_c[j];
        x2a_r <= x2_c[j];
        qa_r  <= q_c[j];
        swa_r <= sw_c[j];
      end
    end

    // reciprocal multiply for the constant divide
    assign qsb = 60'(psa_r) * 60'(RS);
    assign qcb = 60'(pca_r) * 60'(RC);

    always_ff @(posedge clk) begin
      if (en) begin
        psb_r <= psa_r;
        pcb_r <= pca_r;
        qsb_r <= qsb;
        qcb_r <= qcb;
        xb_r  <= xa_r;
        x2b_r <= x2a_r;
        qb_r  <= qa_r;
        swb_r <= swa_r;
      end
    end

    // correct quotient by one and form the next term
    assign dqs = qsb_r[59:30];
    assign dqc = qcb_r[59:30];
    assign rrs = 31'(psb_r) - 31'(dqs) * 31'(DS);
    assign rrc = 31'(pcb_r) - 31'(dqc) * 31'(DC);
    assign tc_nxt = eav_pkg::Q30_ONE - (31'(dqc) + 31'(rrc >= 31'(DC)));
    assign ts_nxt = (j == STEPS - 1) ? {1'b0, psb_r}
                  : eav_pkg::Q30_ONE - (31'(dqs) + 31'(rrs >= 31'(DS)));

    always_ff @(posedge clk) begin
      if (en) begin
        tsc_r <= ts_nxt;
        tcc_r <= tc_nxt;
        xc_r  <= xb_r;
        x2c_r <= x2b_r;
        qc_r  <= qb_r;
        swc_r <= swb_r;
      end
    end

    assign ts_c[j+1] = tsc_r;
    assign tc_c[j+1] = tcc_r;
    assign x_c[j+1]  = xc_r;
    assign x2_c[j+1] = x2c_r;
    assign q_c[j+1]  = qc_r;
    assign sw_c[j+1] = swc_r;
  end

  // round to trig precision, undo the fold and apply the quadrant
  logic [30:0] rs_sum, rc_sum;
  logic signed [TRIG_BITS+1:0] s0, c0, s_nxt, c_nxt;
  logic signed [TRIG_BITS+1:0] sin_r, cos_r;

  always_comb begin
    rs_sum = (ts_c[STEPS] + HALF) >> SH;
    rc_sum = (tc_c[STEPS] + HALF) >> SH;
    if (sw_c[STEPS]) begin
      s0 = signed'({1'b0, rc_sum[TRIG_BITS:0]});
      c0 = signed'({1'b0, rs_sum[TRIG_BITS:0]});
    end else begin
      s0 = signed'({1'b0, rs_sum[TRIG_BITS:0]});
      c0 = signed'({1'b0, rc_sum[TRIG_BITS:0]});
    end
    case (q_c[STEPS])
      eav_pkg::QUAD_0: begin
        s_nxt = s0;
        c_nxt = c0;
      end
      eav_pkg::QUAD_1: begin
        s_nxt = c0;
        c_nxt = -s0;
      end
      eav_pkg::QUAD_2: begin
        s_nxt = -s0;
        c_nxt = -c0;
      end
      default: begin
        s_nxt = -c0;
        c_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= s_nxt;
      cos_r <= c_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== hdl/euler_angle_vector_rotation_unit.sv =====
// Rotates a vector by roll, pitch and yaw angles and returns the saturated
// result. A word enters every cycle while the output does not stall; the
// pipeline is the sine/cosine series (21 stages, two multipliers and a
// constant-divide correction per term) followed by two stages for each of
// the three axis rotations and one saturation stage. A stall at the output
// freezes the whole pipeline; the output register holds its word meanwhile.
// depends on eav_pkg, eav_sincos and euler_angle_vector_rotation_unit_macros.svh
`include "euler_angle_vector_rotation_unit_macros.svh"

module euler_angle_vector_rotation_unit #(
  parameter int TRIG_BITS = eav_pkg::TRIG_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // rotation_order
  input  logic         in_tvalid,
  output logic         in_tready,
  // roll_angle, pitch_angle, yaw_angle (16 each), vec_x, vec_y, vec_z (32 each)
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z (32 each)
  output logic [95:0]  out_tdata
);

  localparam int LAT  = eav_pkg::TRIG_LAT;
  localparam int PL   = eav_pkg::PIPE_LEN;
  localparam int VW   = eav_pkg::VEC_W;
  localparam int IW   = eav_pkg::VEC_IN_W;
  localparam int TW   = TRIG_BITS + 2;
  localparam int PRW  = VW + TW;
  localparam int NRS  = eav_pkg::ROT_STAGES;
  localparam logic signed [PRW:0] HALF = (PRW+1)'(1) <<< (TRIG_BITS - 1);
  localparam logic signed [TW-1:0] ONE_T = TW'(1) <<< TRIG_BITS;

  // configuration register
  logic order_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else if (cfg_wr_en) begin
      order_r <= cfg_wr_data;
    end
  end

  // pipeline valid bits and global advance
  logic en;
  logic [PL-1:0] valid_r, valid_nxt;
  assign en        = !valid_r[PL-1] || out_tready;
  assign in_tready = en;
  assign valid_nxt = {valid_r[PL-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  // trig units, one per angle
  logic signed [TW-1:0] sin_w [3];
  logic signed [TW-1:0] cos_w [3];

  for (genvar a = 0; a < 3; a++) begin : g_trig
    eav_sincos #(.TRIG_BITS(TRIG_BITS)) u_sincos (
      .clk   (clk),
      .en    (en),
      .angle (signed'(in_tdata[16*a +: 16])),
      .sin_o (sin_w[a]),
      .cos_o (cos_w[a])
    );
  end

  // vector delay line matching the trig latency
  logic signed [IW-1:0] vec_line_r [LAT][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vec_line_r[0][i] <= signed'(in_tdata[48 + IW*i +: IW]);
      end
      for (int s = 1; s < LAT; s++) begin
        vec_line_r[s] <= vec_line_r[s-1];
      end
    end
  end

  // rotation stages
  logic signed [VW-1:0] rv_c [NRS+1][3];
  logic signed [TW-1:0] s_c  [NRS+1][3];
  logic signed [TW-1:0] c_c  [NRS+1][3];

  for (genvar i = 0; i < 3; i++) begin : g_rot_in
    assign rv_c[0][i] = VW'(vec_line_r[LAT-1][i]);
    assign s_c[0][i]  = sin_w[i];
    assign c_c[0][i]  = cos_w[i];
  end

  for (genvar k = 0; k < NRS; k++) begin : g_rot
    eav_pkg::axis_t ax;
    logic [1:0] ia, ib, ang;
    logic [1:0] ia_r, ib_r;
    logic signed [PRW-1:0] mca_r, msb_r, mcb_r, msa_r;
    logic signed [VW-1:0] va_r [3];
    logic signed [VW-1:0] vb_r [3];
    logic signed [VW-1:0] vb_nxt [3];
    logic signed [TW-1:0] sa_r [3], ca_r [3], sb_r [3], cb_r [3];
    logic signed [PRW:0] suma, sumb;
    logic signed [VW-1:0] na, nb;

    // axis of this stage
    always_comb begin
      if (k == NRS - 1) begin
        ax = eav_pkg::AX_YAW;
      end else if ((k == 0) ^ order_r) begin
        ax = eav_pkg::AX_ROLL;
      end else begin
        ax = eav_pkg::AX_PITCH;
      end
      case (ax)
        eav_pkg::AX_ROLL: begin
          ia = 2'd1; ib = 2'd2; ang = 2'd0;
        end
        eav_pkg::AX_PITCH: begin
          ia = 2'd2; ib = 2'd0; ang = 2'd1;
        end
        default: begin
          ia = 2'd0; ib = 2'd1; ang = 2'd2;
        end
      endcase
    end

    // products of the two changed components
    always_ff @(posedge clk) begin
      if (en) begin
        mca_r <= PRW'(c_c[k][ang]) * PRW'(rv_c[k][ia]);
        msb_r <= PRW'(s_c[k][ang]) * PRW'(rv_c[k][ib]);
        mcb_r <= PRW'(c_c[k][ang]) * PRW'(rv_c[k][ib]);
        msa_r <= PRW'(s_c[k][ang]) * PRW'(rv_c[k][ia]);
        ia_r  <= ia;
        ib_r  <= ib;
        va_r  <= rv_c[k];
        sa_r  <= s_c[k];
        ca_r  <= c_c[k];
      end
    end

    // sum, round half up and put the components back
    always_comb begin
      suma = (PRW+1)'(mca_r) - (PRW+1)'(msb_r) + HALF;
      sumb = (PRW+1)'(mcb_r) + (PRW+1)'(msa_r) + HALF;
      na   = VW'(suma >>> TRIG_BITS);
      nb   = VW'(sumb >>> TRIG_BITS);
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == ia_r) begin
          vb_nxt[i] = na;
        end else if (2'(i) == ib_r) begin
          vb_nxt[i] = nb;
        end else begin
          vb_nxt[i] = va_r[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vb_r <= vb_nxt;
        sb_r <= sa_r;
        cb_r <= ca_r;
      end
    end

    assign rv_c[k+1] = vb_r;
    assign s_c[k+1]  = sb_r;
    assign c_c[k+1]  = cb_r;
  end

  // saturation into the output register
  logic [IW-1:0] out_r   [3];
  logic [IW-1:0] out_nxt [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (rv_c[NRS][i][VW-1:IW-1] == '0 || rv_c[NRS][i][VW-1:IW-1] == '1) begin
        out_nxt[i] = rv_c[NRS][i][IW-1:0];
      end else if (rv_c[NRS][i][VW-1]) begin
        out_nxt[i] = {1'b1, {(IW-1){1'b0}}};
      end else begin
        out_nxt[i] = {1'b0, {(IW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = valid_r[PL-1];
  assign out_tdata  = {out_r[2], out_r[1], out_r[0]};

  // checks
  `EAV_ASSERT_NEXT(a_stall_freezes, !in_tready, valid_r == $past(valid_r))
  `EAV_ASSERT_NEXT(a_bubble_enters, in_tready && !in_tvalid, !valid_r[0])
  `EAV_ASSERT_HOLD(a_sin_range, !valid_r[LAT-1] || (sin_w[0] <= ONE_T && sin_w[0] >= -ONE_T))
  `EAV_ASSERT_HOLD(a_cos_range, !valid_r[LAT-1] || (cos_w[2] <= ONE_T && cos_w[2] >= -ONE_T))

endmodule

// ===== sim/tb_euler_angle_vector_rotation_unit.sv =====
// testbench for the euler angle vector rotation unit: directed and random words,
// both rotation orders, random idling on both sides and a long output hold-off
// depends on eav_pkg and euler_angle_vector_rotation_unit
module tb_euler_angle_vector_rotation_unit;

  localparam int TB_TRIG = 16;
  localparam longint unsigned Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec3_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;

  // rotated vectors still owed by the block, oldest first
  vec3_t rotated_due[$];
  bit    order_gimbal = 1'b0;
  bit    tx_gaps = 1'b1;
  bit    rx_gaps = 1'b1;
  int    hold_cycles = 0;
  int    mismatches = 0;
  int    words_sent = 0;
  int    words_checked = 0;

  euler_angle_vector_rotation_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // taylor series in q30, sine or cosine of f hundredths of a degree
  function automatic longint unsigned q30_series(int unsigned f, bit is_sin);
    longint unsigned x, x2, t, d;
    int n;
    x  = (longint'(f) * PI_Q30) / 18000;
    x2 = (x * x) >> 30;
    t  = Q30;
    for (n = 0; n < (is_sin ? 4 : 5); n++) begin
      if (is_sin) d = (n == 0) ? 72 : (n == 1) ? 42 : (n == 2) ? 20 : 6;
      else d = (n == 0) ? 90 : (n == 1) ? 56 : (n == 2) ? 30 : (n == 3) ? 12 : 2;
      t = Q30 - ((x2 * t) >> 30) / d;
    end
    return is_sin ? ((x * t) >> 30) : t;
  endfunction

  function automatic longint q30_to_trig(longint unsigned v);
    return longint'((v + (64'd1 << (29 - TB_TRIG))) >> (30 - TB_TRIG));
  endfunction

  task automatic angle_sincos(input logic signed [15:0] ang, output longint s, output longint c);
    int r;
    int unsigned f;
    longint s0, c0;
    eav_pkg::quad_t qd;
    r = int'(ang) % 36000;
    if (r < 0) r += 36000;
    qd = eav_pkg::quad_t'(r / 9000);
    f  = r % 9000;
    if (f <= 4500) begin
      s0 = q30_to_trig(q30_series(f, 1'b1));
      c0 = q30_to_trig(q30_series(f, 1'b0));
    end else begin
      s0 = q30_to_trig(q30_series(9000 - f, 1'b0));
      c0 = q30_to_trig(q30_series(9000 - f, 1'b1));
    end
    case (qd)
      eav_pkg::QUAD_0: begin s = s0;  c = c0;  end
      eav_pkg::QUAD_1: begin s = c0;  c = -s0; end
      eav_pkg::QUAD_2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endtask

  // c*p -/+ s*q with round half up at the trig scale
  function automatic longint mix_round(longint c, longint p, longint s, longint q, bit sub);
    longint v;
    v = sub ? (c * p - s * q) : (c * p + s * q);
    v += longint'(1) << (TB_TRIG - 1);
    if (v >= 0) return v >>> TB_TRIG;
    return -(((-v) + ((longint'(1) << TB_TRIG) - 1)) >>> TB_TRIG);
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  task automatic predict_rotation(input logic [159:0] w, input bit gimbal, output vec3_t res);
    longint sr, cr, sp, cp, sy, cy, vx, vy, vz, a, b;
    angle_sincos(w[15:0], sr, cr);
    angle_sincos(w[31:16], sp, cp);
    angle_sincos(w[47:32], sy, cy);
    vx = longint'($signed(w[79:48]));
    vy = longint'($signed(w[111:80]));
    vz = longint'($signed(w[143:112]));
    for (int st = 0; st < 2; st++) begin
      if ((st == 0) != gimbal) begin
        // roll about x
        a = mix_round(cr, vy, sr, vz, 1'b1);
        b = mix_round(cr, vz, sr, vy, 1'b0);
        vy = a; vz = b;
      end else begin
        // pitch about y
        a = mix_round(cp, vx, sp, vz, 1'b0);
        b = mix_round(cp, vz, sp, vx, 1'b1);
        vx = a; vz = b;
      end
    end
    a = mix_round(cy, vx, sy, vy, 1'b1);
    b = mix_round(cy, vy, sy, vx, 1'b0);
    res.x = clamp32(a);
    res.y = clamp32(b);
    res.z = clamp32(vz);
  endtask

  // offer one word and record its rotation once accepted
  task automatic send_word(input logic [15:0] roll, pitch, yaw, input logic [31:0] vx, vy, vz);
    vec3_t res;
    logic [159:0] w;
    w = {16'h0, vz, vy, vx, yaw, pitch, roll};
    while (tx_gaps && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    predict_rotation(w, order_gimbal, res);
    rotated_due.push_back(res);
    words_sent++;
  endtask

  function automatic logic [15:0] rand_angle();
    if ($urandom_range(99) < 80) return 16'($urandom_range(36000) - 18000);
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] rand_comp();
    int k;
    k = $urandom_range(99);
    if (k < 50) return $urandom;
    if (k < 80) return 32'($urandom_range(1 << 22) - (1 << 21));
    if (k < 90) return 32'h7FFF_FFFF - $urandom_range(1000);
    return 32'h8000_0000 + $urandom_range(1000);
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_word(rand_angle(), rand_angle(), rand_angle(), 32'($urandom_range(1 << 24)), 0, 0);
      else
        send_word(rand_angle(), rand_angle(), rand_angle(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  // drain the pipeline and then write the order register
  task automatic set_order(bit gimbal);
    in_tvalid <= 1'b0;
    while (rotated_due.size() != 0) @(posedge clk);
    repeat (eav_pkg::PIPE_LEN + 4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= gimbal;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_gimbal = gimbal;
  endtask

  task automatic test_directed();
    logic [15:0] corners[12] = '{16'h0, 16'd4500, 16'd4501, 16'd9000, 16'd18000, -16'sd18000,
                                 16'd27000, -16'sd9000, 16'h7FFF, 16'h8000, 16'd36000, 16'd1};
    for (int i = 0; i < 12; i++)
      send_word(corners[i], corners[(i + 3) % 12], corners[(i + 7) % 12],
                32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
    // camera ray and saturating extremes
    send_word(16'd1000, -16'sd2000, 16'd3000, 32'h0064_0000, 0, 0);
    send_word(16'd4500, 16'd4500, 16'd4500, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(16'd4500, 16'd4500, 16'd4500, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_no_idle();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random(300);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    tx_gaps = 1'b0;
    send_random(80);
    tx_gaps = 1'b1;
  endtask

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    vec3_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (rotated_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_tdata);
      end else begin
        want = rotated_due.pop_front();
        words_checked++;
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch x exp %h got %h, y exp %h got %h, z exp %h got %h",
                     want.x, got.x, want.y, got.y, want.z, got.z);
        end
      end
    end
  end

  // receiver: long hold-off counted down in cycles, else random idling while rx_gaps is set
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else out_tready <= !(rx_gaps && $urandom_range(99) < 37);
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_random(300);
    test_no_idle();
    test_backpressure();
    set_order(1'b1);
    test_directed();
    send_random(400);
    set_order(1'b0);
    send_random(200);
    in_tvalid <= 1'b0;
    while (rotated_due.size() != 0) @(posedge clk);
    repeat (eav_pkg::PIPE_LEN + 10) @(posedge clk);
    $display("covered %0d words, %0d checked, both rotation orders", words_sent, words_checked);
    $display("with angle corners, saturation, random idling and a long output hold-off");
    if (mismatches == 0 && rotated_due.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
